FILE: rtl/deque_with_search_macros.svh
// Assertion macros shared by the deque RTL.
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define DWS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define DWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define DWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dws_pkg.sv
package dws_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed port widths
    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // Operation codes
    localparam logic [FUNC_W-1:0] F_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] F_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] F_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] F_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] F_PEEK       = 3'd4;
    localparam logic [FUNC_W-1:0] F_FIND       = 3'd5;
    localparam logic [FUNC_W-1:0] F_REMOVE     = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

endpackage

FILE: rtl/deque_with_search.sv
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+----------------------------------------
// request  | in  | in_valid / in_stall    | func, value
// result   | out | out_valid / out_stall  | data_out, position, status, count
//
// One request is taken at a time; in_stall stays high until its result is
// in the output register. Push and operations refused as empty or full go
// from the start state straight to done; pop and peek pass a read state.
// Find scans from the front up to the index reached (a missing key walks the
// whole count); remove then shifts each later word one place toward the
// front. Scan and shift use the store's single read port, one word per cycle.
// Reset clears head pointer, count and all handshake state; the store
// itself is not cleared. A stalled result holds in the output register
// while the next request may already be accepted and worked on.
`include "deque_with_search_macros.svh"

module deque_with_search
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dws_pkg::FUNC_W-1:0]    func,
    input  logic [dws_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dws_pkg::VALUE_W-1:0]   data_out,
    output logic [dws_pkg::POS_W-1:0]     position,
    output logic [dws_pkg::STAT_W-1:0]    status,
    output logic [dws_pkg::COUNT_W-1:0]   count
);
    import dws_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Circular index: (h + k) mod DEPTH, with h + k below twice DEPTH.
    function automatic addr_t slot_of(input addr_t h, input cnt_t k);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(h) + (CNT_W+1)'(k);
        if (s >= (CNT_W+1)'(DEPTH))
            s = s - (CNT_W+1)'(DEPTH);
        return ADDR_W'(s);
    endfunction

    logic [2:0]          state_reg,      state_next;
    addr_t               head_reg,       head_next;
    cnt_t                occ_reg,        occ_next;
    addr_t               idx_reg,        idx_next;
    logic [FUNC_W-1:0]   func_reg,       func_next;
    word_t               key_reg,        key_next;
    word_t               res_data_reg,   res_data_next;
    addr_t               res_pos_reg,    res_pos_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;

    logic                out_valid_reg,  out_valid_next;
    logic [VALUE_W-1:0]  out_data_reg,   out_data_next;
    logic [POS_W-1:0]    out_pos_reg,    out_pos_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg,  out_count_next;

    // Store: one write port, one registered read port
    word_t               mem [DEPTH];
    word_t               rdata_reg;
    logic                mem_we;
    addr_t               mem_waddr;
    word_t               mem_wdata;
    addr_t               mem_raddr;

    logic                in_accept;
    logic [63:0]         value_wide;
    logic [63:0]         res_data_wide;
    addr_t               head_dec;
    cnt_t                idx_p1;
    cnt_t                idx_p2;

    assign in_stall      = (state_reg != S_IDLE);
    assign in_accept     = in_valid && !in_stall;
    assign value_wide    = 64'(value);
    assign res_data_wide = 64'(res_data_reg);
    assign head_dec      = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    assign idx_p1        = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_p2        = CNT_W'(idx_reg) + CNT_W'(2);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        res_data_next   = res_data_reg;
        res_pos_next    = res_pos_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = head_reg;
        mem_wdata       = rdata_reg;
        mem_raddr       = head_reg;

        // Drain the output register when the sink takes the beat
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        out_pos_next    = out_pos_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    func_next  = func;
                    key_next   = value_wide[DATA_WIDTH-1:0];
                    state_next = S_START;
                end
            end
            S_START:
            begin
                res_data_next   = '0;
                res_pos_next    = '0;
                res_status_next = ST_OK;
                state_next      = S_DONE;
                case (func_reg)
                    F_PUSH_FRONT:
                    begin
                        if (occ_reg == CNT_W'(DEPTH))
                            res_status_next = ST_FULL;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = head_dec;
                            mem_wdata = key_reg;
                            head_next = head_dec;
                            occ_next  = occ_reg + CNT_W'(1);
                        end
                    end
                    F_PUSH_BACK:
                    begin
                        if (occ_reg == CNT_W'(DEPTH))
                            res_status_next = ST_FULL;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = slot_of(head_reg, occ_reg);
                            mem_wdata = key_reg;
                            occ_next  = occ_reg + CNT_W'(1);
                        end
                    end
                    F_POP_FRONT:
                    begin
                        if (occ_reg == '0)
                            res_status_next = ST_EMPTY;
                        else
                        begin
                            mem_raddr  = head_reg;
                            head_next  = slot_of(head_reg, CNT_W'(1));
                            occ_next   = occ_reg - CNT_W'(1);
                            state_next = S_READ;
                        end
                    end
                    F_POP_BACK:
                    begin
                        if (occ_reg == '0)
                            res_status_next = ST_EMPTY;
                        else
                        begin
                            mem_raddr  = slot_of(head_reg, occ_reg - CNT_W'(1));
                            occ_next   = occ_reg - CNT_W'(1);
                            state_next = S_READ;
                        end
                    end
                    F_PEEK:
                    begin
                        if (occ_reg == '0)
                            res_status_next = ST_EMPTY;
                        else
                        begin
                            mem_raddr  = head_reg;
                            state_next = S_READ;
                        end
                    end
                    F_FIND, F_REMOVE:
                    begin
                        if (occ_reg == '0)
                            res_status_next = ST_EMPTY;
                        else
                        begin
                            mem_raddr  = head_reg;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                res_data_next = rdata_reg;
                state_next    = S_DONE;
            end
            S_SCAN:
            begin
                // Compare the word at idx, fetch the one after it ahead of time
                mem_raddr = slot_of(head_reg, idx_p1);
                if (rdata_reg == key_reg)
                begin
                    if (func_reg == F_FIND)
                    begin
                        res_pos_next = idx_reg;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        res_data_next = rdata_reg;
                        if (idx_p1 == occ_reg)
                        begin
                            occ_next   = occ_reg - CNT_W'(1);
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_SHIFT;
                    end
                end
                else if (idx_p1 == occ_reg)
                begin
                    res_status_next = ST_MISSING;
                    state_next      = S_DONE;
                end
                else
                    idx_next = ADDR_W'(idx_p1);
            end
            S_SHIFT:
            begin
                // Move word idx+1 into idx, fetch idx+2
                mem_we    = 1'b1;
                mem_waddr = slot_of(head_reg, CNT_W'(idx_reg));
                mem_wdata = rdata_reg;
                mem_raddr = slot_of(head_reg, idx_p2);
                if (idx_p2 == occ_reg)
                begin
                    occ_next   = occ_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                    idx_next = ADDR_W'(idx_p1);
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_wide[VALUE_W-1:0];
                    out_pos_next    = POS_W'(res_pos_reg);
                    out_status_next = res_status_reg;
                    out_count_next  = COUNT_W'(occ_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        func_reg       <= func_next;
        key_reg        <= key_next;
        res_data_reg   <= res_data_next;
        res_pos_reg    <= res_pos_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_pos_reg    <= out_pos_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign position  = out_pos_reg;
    assign status    = out_status_reg;
    assign count     = out_count_reg;

    `DWS_ASSERT_ALWAYS(a_occ_bound, occ_reg <= CNT_W'(DEPTH), "count beyond depth")
    `DWS_ASSERT_NEXT(a_accept_start, in_accept, state_reg == S_START, "accept did not start")
    `DWS_ASSERT_SAME(a_scan_idx, state_reg == S_SCAN || state_reg == S_SHIFT, CNT_W'(idx_reg) < occ_reg, "scan index past count")
    `DWS_ASSERT_SAME(a_write_state, mem_we, state_reg == S_START || state_reg == S_SHIFT, "store write outside start or shift")
    `DWS_ASSERT_NEXT(a_done_load, state_reg == S_DONE && state_next == S_IDLE, out_valid_reg, "result not loaded")

endmodule
